// ===== hw/rtl/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared constants and types of the marching tetrahedron triangulator.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int unsigned CoordW     = 16;
    localparam int unsigned ValW       = 16;
    localparam int unsigned CornerW    = 64;
    localparam int unsigned NumCorners = 4;
    localparam int unsigned NumEdges   = 4;
    localparam int unsigned NumAxes    = 3;
    localparam int unsigned OutW       = 144;
    localparam logic [15:0] ThrReset   = 16'd2540;
    // Signed product of a 17-bit position delta and a 17-bit value delta.
    localparam int unsigned ProdW      = 34;
    // Rounded dividend 2*|n| + |d| and the quotient bits that replace it.
    localparam int unsigned DivW       = 35;
    localparam int unsigned DvsW       = 18;
    localparam int unsigned CntW       = 6;

    typedef enum logic [1:0] {
        TRI_ONE    = 2'd0,
        TRI_PAIR_A = 2'd1,
        TRI_PAIR_B = 2'd2
    } t_tri_sel;

    typedef struct packed {
        logic       store;
        logic [1:0] slot;
        logic       rd_en;
        logic [1:0] rd_addr;
        logic       ld_a;
        logic       ld_b;
        logic       mul;
        logic [1:0] axis;
        logic       prep;
        logic       div_step;
        logic       fin;
        logic [1:0] edge_idx;
        logic       out_load;
        t_tri_sel   out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] in_mask;
        logic       out_busy;
    } t_dp_sts;

endpackage

// ===== hw/rtl/mtt_datapath.sv =====
// ----------------------------------------------------------------------------
// mtt_datapath
// Corner store, crossing arithmetic with a bit-serial divider, result store
// and the output register.
// ----------------------------------------------------------------------------
module mtt_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mtt_pkg::t_dp_cmd         i_cmd,
    output mtt_pkg::t_dp_sts         o_sts,
    input  logic                     i_cfg_wr_en,
    input  logic [15:0]              i_cfg_wr_data,
    input  logic [63:0]              i_corner,
    output logic                     o_tvalid,
    input  logic                     i_tready,
    output logic [mtt_pkg::OutW-1:0] o_tdata,
    output logic                     o_tlast
);

    logic [63:0] r_mem [mtt_pkg::NumCorners];
    logic [63:0] r_rd;
    logic [15:0] r_val [mtt_pkg::NumCorners];
    logic [15:0] r_thr;
    logic [63:0] r_ca;
    logic [63:0] r_cb;
    logic signed [15:0] r_pa;
    logic signed [mtt_pkg::ProdW-1:0] r_prod;
    logic signed [16:0] r_den;
    logic r_neg;
    logic [mtt_pkg::DivW-1:0] r_dvd;
    logic [mtt_pkg::DvsW-1:0] r_dvs;
    logic [mtt_pkg::DvsW-1:0] r_rem;
    logic [15:0] r_pt [mtt_pkg::NumEdges][mtt_pkg::NumAxes];
    logic r_valid;
    logic [mtt_pkg::OutW-1:0] r_out;
    logic r_last;

    logic signed [15:0] pa, pb;
    logic signed [16:0] d, va, vb, num, den;
    logic [mtt_pkg::ProdW-1:0] prod_abs;
    logic [16:0] den_abs;
    logic [mtt_pkg::DvsW:0] rem_s;
    logic rem_ge;
    logic signed [36:0] sq, sum;
    logic [15:0] sat;

    // Corner memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_cmd.slot] <= i_corner;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mtt_pkg::ThrReset;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_val[i_cmd.slot] <= i_corner[63:48];
        end
    end

    always_comb begin
        for (int i = 0; i < mtt_pkg::NumCorners; i++) begin
            o_sts.in_mask[i] = (r_val[i] >= r_thr);
        end
        o_sts.out_busy = r_valid && !i_tready;
    end

    always_comb begin
        pa      = r_ca[{i_cmd.axis, 4'b0000} +: 16];
        pb      = r_cb[{i_cmd.axis, 4'b0000} +: 16];
        d       = {pb[15], pb} - {pa[15], pa};
        va      = {1'b0, r_ca[63:48]};
        vb      = {1'b0, r_cb[63:48]};
        num     = {1'b0, r_thr} - va;
        den     = vb - va;
        // Equal end values put the crossing at the midpoint.
        if (den == 17'sd0) begin
            num = 17'sd1;
            den = 17'sd2;
        end
        prod_abs = r_prod[mtt_pkg::ProdW-1] ? mtt_pkg::ProdW'(-r_prod)
                                             : mtt_pkg::ProdW'(r_prod);
        den_abs  = r_den[16] ? 17'(-r_den) : 17'(r_den);
        rem_s    = {r_rem, r_dvd[mtt_pkg::DivW-1]};
        rem_ge   = (rem_s >= {1'b0, r_dvs});
        sq       = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
        sum      = sq + 37'(r_pa);
        if (sum > 37'sd32767) begin
            sat = 16'h7fff;
        end else if (sum < -37'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) begin
            r_ca <= r_rd;
        end
        if (i_cmd.ld_b) begin
            r_cb <= r_rd;
        end
        if (i_cmd.mul) begin
            r_prod <= d * num;
            r_den  <= den;
            r_pa   <= pa;
        end
        if (i_cmd.prep) begin
            // Round to nearest, ties away: (2|n| + |d|) / (2|d|).
            r_neg <= r_prod[mtt_pkg::ProdW-1] != r_den[16];
            r_dvd <= {prod_abs, 1'b0} + mtt_pkg::DivW'(den_abs);
            r_dvs <= {den_abs, 1'b0};
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[mtt_pkg::DivW-2:0], rem_ge};
            r_rem <= rem_ge ? mtt_pkg::DvsW'(rem_s - {1'b0, r_dvs})
                            : mtt_pkg::DvsW'(rem_s);
        end
        if (i_cmd.fin) begin
            r_pt[i_cmd.edge_idx][i_cmd.axis] <= sat;
        end
    end

    function automatic logic [mtt_pkg::OutW-1:0] pack_tri(
        input logic [15:0] a0, input logic [15:0] a1, input logic [15:0] a2,
        input logic [15:0] b0, input logic [15:0] b1, input logic [15:0] b2,
        input logic [15:0] c0, input logic [15:0] c1, input logic [15:0] c2
    );
        return {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                mtt_pkg::TRI_PAIR_A: begin
                    r_out  <= pack_tri(r_pt[0][0], r_pt[0][1], r_pt[0][2],
                                       r_pt[2][0], r_pt[2][1], r_pt[2][2],
                                       r_pt[3][0], r_pt[3][1], r_pt[3][2]);
                    r_last <= 1'b0;
                end
                mtt_pkg::TRI_PAIR_B: begin
                    r_out  <= pack_tri(r_pt[0][0], r_pt[0][1], r_pt[0][2],
                                       r_pt[3][0], r_pt[3][1], r_pt[3][2],
                                       r_pt[1][0], r_pt[1][1], r_pt[1][2]);
                    r_last <= 1'b1;
                end
                default: begin
                    r_out  <= pack_tri(r_pt[0][0], r_pt[0][1], r_pt[0][2],
                                       r_pt[1][0], r_pt[1][1], r_pt[1][2],
                                       r_pt[2][0], r_pt[2][1], r_pt[2][2]);
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_out;
    assign o_tlast  = r_last;

endmodule

// ===== hw/rtl/mtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer: corner intake, classification, edge walk and triangle output.
// ----------------------------------------------------------------------------
module mtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic             i_tlast,
    input  mtt_pkg::t_dp_sts i_sts,
    output mtt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLS, S_RDA, S_RDB, S_LDB, S_MUL, S_PREP, S_DIV, S_FIN,
        S_OUT1, S_OUT2
    } t_state;

    t_state r_state;
    logic [1:0] r_count;
    logic [1:0] r_ea [mtt_pkg::NumEdges];
    logic [1:0] r_eb [mtt_pkg::NumEdges];
    logic r_pair;
    logic [1:0] r_edge;
    logic [1:0] r_axis;
    logic [mtt_pkg::CntW-1:0] r_cnt;

    logic [1:0] ins [4];
    logic [1:0] outs [4];
    logic [2:0] n_in;
    logic [2:0] n_out;
    logic [1:0] ea [mtt_pkg::NumEdges];
    logic [1:0] eb [mtt_pkg::NumEdges];
    logic [1:0] last_edge;

    // Split the corners into inside and outside lists, each in corner order.
    always_comb begin
        n_in  = '0;
        n_out = '0;
        for (int i = 0; i < 4; i++) begin
            ins[i]  = '0;
            outs[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (i_sts.in_mask[i]) begin
                ins[n_in[1:0]] = 2'(i);
                n_in = n_in + 3'd1;
            end else begin
                outs[n_out[1:0]] = 2'(i);
                n_out = n_out + 3'd1;
            end
        end
        for (int e = 0; e < 4; e++) begin
            ea[e] = '0;
            eb[e] = '0;
        end
        if (n_in == 3'd2) begin
            ea[0] = ins[0]; eb[0] = outs[0];
            ea[1] = ins[0]; eb[1] = outs[1];
            ea[2] = ins[1]; eb[2] = outs[0];
            ea[3] = ins[1]; eb[3] = outs[1];
        end else if (n_in == 3'd1) begin
            for (int e = 0; e < 3; e++) begin
                ea[e] = ins[0];
                eb[e] = outs[e];
            end
        end else begin
            for (int e = 0; e < 3; e++) begin
                ea[e] = outs[0];
                eb[e] = ins[e];
            end
        end
        last_edge = r_pair ? 2'd3 : 2'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pair  <= 1'b0;
            r_edge  <= '0;
            r_axis  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_tvalid) begin
                        if (i_tlast) begin
                            r_count <= '0;
                            r_state <= S_CLS;
                        end else begin
                            r_count <= r_count + 2'd1;
                        end
                    end
                end
                S_CLS: begin
                    if (n_in == 3'd0 || n_in == 3'd4) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ea    <= ea;
                        r_eb    <= eb;
                        r_pair  <= (n_in == 3'd2);
                        r_edge  <= '0;
                        r_state <= S_RDA;
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: r_state <= S_LDB;
                S_LDB: begin
                    r_axis  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_PREP;
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mtt_pkg::CntW'(mtt_pkg::DivW - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_axis == 2'(mtt_pkg::NumAxes - 1)) begin
                        if (r_edge == last_edge) begin
                            r_state <= S_OUT1;
                        end else begin
                            r_edge  <= r_edge + 2'd1;
                            r_state <= S_RDA;
                        end
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT1: begin
                    if (!i_sts.out_busy) begin
                        r_state <= r_pair ? S_OUT2 : S_IDLE;
                    end
                end
                S_OUT2: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.slot     = r_count;
        o_cmd.axis     = r_axis;
        o_cmd.edge_idx = r_edge;
        o_cmd.out_sel  = mtt_pkg::TRI_ONE;
        o_tready       = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.store = i_tvalid;
            S_RDA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_ea[r_edge];
            end
            S_RDB: begin
                o_cmd.ld_a    = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_eb[r_edge];
            end
            S_LDB:  o_cmd.ld_b = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_PREP: o_cmd.prep = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_FIN:  o_cmd.fin = 1'b1;
            S_OUT1: begin
                o_cmd.out_load = !i_sts.out_busy;
                o_cmd.out_sel  = r_pair ? mtt_pkg::TRI_PAIR_A : mtt_pkg::TRI_ONE;
            end
            S_OUT2: begin
                o_cmd.out_load = !i_sts.out_busy;
                o_cmd.out_sel  = mtt_pkg::TRI_PAIR_B;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A new triangle never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("triangle loaded over a pending beat");

    // The divider runs exactly its bit count before finishing.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_cnt == mtt_pkg::CntW'(mtt_pkg::DivW)))
        else $error("divider finished early");

    // A second triangle only follows a two-inside split.
    a_pair_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT2) |-> r_pair)
        else $error("second triangle without two-inside split");
`endif

endmodule

// ===== hw/rtl/marching_tetrahedron_triangulator_core.sv =====
// ----------------------------------------------------------------------------
// marching_tetrahedron_triangulator_core
// Cuts a tetrahedron by an iso-surface and emits zero, one or two triangles.
// ----------------------------------------------------------------------------
// Input beats carry one corner each (x, y, z, value); s_axis_tlast marks the
// fourth corner and starts triangulation. Output beats carry one triangle;
// m_axis_tlast marks the last triangle of a tetrahedron. i_cfg_wr_en writes
// the iso threshold (reset 2540); the user must use it only while the block
// is idle, and the block itself does not enforce this. Corners without tlast
// are taken at one per cycle while the block is idle. After the last corner
// the block classifies the corners, then walks the crossed edges; each
// edge reads its two corners, then runs 3 axes, each a multiply, a setup, a
// bit-serial rounding divide and a saturate. All edges and axes share the
// one serial divider. s_axis_tready is low while a tetrahedron is being
// worked. A stalled receiver holds the output register, and the block
// waits before loading a second triangle; once the last triangle is
// registered new corners are accepted again. Reset clears the corner count
// and the output valid and sets the threshold to 2540; stored corners are
// not cleared.
module marching_tetrahedron_triangulator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, corner_value
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,  // v0_x, v0_y, v0_z, v1_x .. v2_z
    output logic         m_axis_tlast
);

    mtt_pkg::t_dp_cmd cmd;
    mtt_pkg::t_dp_sts sts;

    mtt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tlast  (s_axis_tlast),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    mtt_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_corner      (s_axis_tdata),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_tlast       (m_axis_tlast)
    );

endmodule

// ===== sim/marching_tetrahedron_triangulator_core_tb.sv =====
// ----------------------------------------------------------------------------
// marching_tetrahedron_triangulator_core_tb
// Streams tetrahedron corners into the triangulator and checks each triangle
// against a predictor of the iso-surface cut, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marching_tetrahedron_triangulator_core_tb;

    typedef struct packed {
        logic [15:0] val;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } t_corner;

    typedef struct packed {
        logic         last;
        t_corner      c;
    } t_beat;

    typedef struct packed {
        logic         last;
        logic [143:0] verts;
    } t_tri;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [15:0]  i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tlast;

    marching_tetrahedron_triangulator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_beat   corner_queue[$];
    t_tri    triangle_queue[$];
    t_corner slots[4];
    logic [1:0]  slot_ptr = '0;
    logic [15:0] iso_level = mtt_pkg::ThrReset;
    int      mismatches = 0;
    int      in_flight = 0;
    bit      long_stall = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;

    // Position pa + round((pb-pa)*(thr-va)/(vb-va)), ties away from zero.
    function automatic logic [15:0] lerp_axis(logic [15:0] pa16, logic [15:0] pb16,
                                              logic [15:0] va, logic [15:0] vb);
        longint pa, n, d, un, ud, q, r;
        pa = longint'($signed(pa16));
        n = longint'(iso_level) - longint'(va);
        d = longint'(vb) - longint'(va);
        if (d == 0) begin
            n = 1;
            d = 2;
        end
        n = (longint'($signed(pb16)) - pa) * n;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un * 2 + ud) / (ud * 2);
        if ((n < 0) != (d < 0)) q = -q;
        r = pa + q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [47:0] edge_point(t_corner a, t_corner b);
        return {lerp_axis(a.z, b.z, a.val, b.val), lerp_axis(a.y, b.y, a.val, b.val),
                lerp_axis(a.x, b.x, a.val, b.val)};
    endfunction

    task automatic predict_triangles(t_beat b);
        t_corner ins[$], outs[$];
        t_corner pv;
        slots[slot_ptr] = b.c;
        if (!b.last) begin
            slot_ptr = slot_ptr + 2'd1;
            return;
        end
        slot_ptr = '0;
        for (int i = 0; i < 4; i++)
            if (slots[i].val >= iso_level) ins.push_back(slots[i]);
            else outs.push_back(slots[i]);
        if (ins.size() == 1 || ins.size() == 3) begin
            pv = ins.size() == 1 ? ins[0] : outs[0];
            if (ins.size() == 3) outs = ins;
            triangle_queue.push_back({1'b1, edge_point(pv, outs[2]),
                edge_point(pv, outs[1]), edge_point(pv, outs[0])});
        end else if (ins.size() == 2) begin
            triangle_queue.push_back({1'b0, edge_point(ins[1], outs[1]),
                edge_point(ins[1], outs[0]), edge_point(ins[0], outs[0])});
            triangle_queue.push_back({1'b1, edge_point(ins[0], outs[1]),
                edge_point(ins[1], outs[1]), edge_point(ins[0], outs[0])});
        end
    endtask

    function automatic t_corner rand_corner(int vmode);
        t_corner c;
        c.x = 16'($urandom);
        c.y = 16'($urandom);
        c.z = 16'($urandom);
        case (vmode)
            0: c.val = 16'($urandom);
            1: c.val = 16'(iso_level + $urandom_range(0, 300) - 150);
            default: c.val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return c;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_triangles({s_axis_tlast, s_axis_tdata});
                in_flight = in_flight - 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) gap_left--;
                if (corner_queue.size() > 0 && gap_left == 0) begin
                    {s_axis_tlast, s_axis_tdata} <= corner_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        t_tri got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata};
                if (triangle_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected triangle %h", got);
                end else begin
                    want = triangle_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("triangle mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            m_axis_tready <= !long_stall && ($urandom_range(0, 3) != 0 ||
                             $urandom_range(0, 1) == 0);
        end
    end

    task automatic queue_tet(int vmode, bit early);
        int n;
        n = early ? $urandom_range(1, 3) : 4;
        for (int i = 0; i < n; i++) begin
            corner_queue.push_back({i == n - 1 ? 1'b1 : 1'b0, rand_corner(vmode)});
            in_flight++;
        end
    endtask

    task automatic queue_fixed(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                               logic [15:0] v3, logic [15:0] p);
        corner_queue.push_back({1'b0, v0, p, 16'h8000, 16'h7FFF});
        corner_queue.push_back({1'b0, v1, 16'h7FFF, p, 16'h8000});
        corner_queue.push_back({1'b0, v2, 16'h8000, 16'h7FFF, p});
        corner_queue.push_back({1'b1, v3, 16'h0000, 16'hFFFF, 16'h0001});
        in_flight += 4;
    endtask

    task automatic drain();
        while (in_flight > 0 || triangle_queue.size() > 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_level(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        iso_level = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] levels[5];
        levels = '{16'd0, 16'hFFFF, 16'd2540, 16'd1, 16'h8000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases at the reset threshold: no, one, two and all corners inside, equal values.
        queue_fixed(16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
        queue_fixed(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
        queue_fixed(16'd2540, 16'd0, 16'd0, 16'd0, 16'h0000);
        queue_fixed(16'd0, 16'hFFFF, 16'hFFFF, 16'd2539, 16'h7FFF);
        queue_fixed(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'h8000);
        queue_fixed(16'd0, 16'd0, 16'd2540, 16'd2540, 16'h1234);
        // Early last marks reuse older slots.
        corner_queue.push_back({1'b1, 16'd0, 16'h7FFF, 16'h8000, 16'h0000});
        corner_queue.push_back({1'b0, 16'hFFFF, 16'h1, 16'h2, 16'h3});
        corner_queue.push_back({1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF});
        in_flight += 3;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_level(levels[ph]);
            for (int t = 0; t < 85; t++) begin
                // The sender pauses midway until every pending triangle is out.
                if (ph == 1 && t == 40) drain();
                queue_tet($urandom_range(0, 2), $urandom_range(0, 9) == 0);
            end
            if (ph == 2) begin
                long_stall = 1'b1;
                repeat (3000) @(posedge i_clk);
                long_stall = 1'b0;
            end
            drain();
        end
        if (mismatches == 0)
            $display("marching_tetrahedron_triangulator_core test passed");
        else
            $display("marching_tetrahedron_triangulator_core test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("marching_tetrahedron_triangulator_core test failed");
        $finish;
    end
endmodule
